@@ rtl/tpcra_pkg.sv @@
// ---------------------------------------------------------------------------
// tpcra_pkg
// Shared types and constants of the thermal colorizer with window average.
// ---------------------------------------------------------------------------
package tpcra_pkg;

  // default geometry
  localparam int FRAME_WIDTH_DEF   = 32;
  localparam int FRAME_HEIGHT_DEF  = 32;
  localparam int WINDOW_WIDTH_DEF  = 4;
  localparam int WINDOW_HEIGHT_DEF = 4;

  // field widths
  localparam int RAW_W     = 16;
  localparam int TEMP_W    = 15;
  localparam int OFFSET_W  = 11;
  localparam int ROI_W     = 5;
  localparam int PAL_IDX_W = 11;
  localparam int WORD_W    = 32;
  localparam int DIGIT_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  // conversion constants
  localparam int PALETTE_SIZE = 1200;
  localparam int KELVIN_BIAS  = 2732;
  localparam int INDEX_BIAS   = 600;
  localparam int INDEX_MAX    = 1199;
  localparam int TEMP_MAX     = 32767;

  // decimal digits of a TEMP_W-bit value, exact reciprocals
  localparam int DIGIT_BASE     = 10;
  localparam int HUNDRED        = 100;
  localparam int THOUSAND       = 1000;
  localparam int THOUSANDS_MAX  = 9;
  localparam int OVERFLOW_LIMIT = 10000;
  localparam int RECIP_DIG_W    = 16;
  localparam int PROD_DIG_W     = TEMP_W + RECIP_DIG_W;
  localparam logic [RECIP_DIG_W-1:0] DIV10_MUL   = 16'd52429;
  localparam int                     DIV10_SH    = 19;
  localparam logic [RECIP_DIG_W-1:0] DIV100_MUL  = 16'd41944;
  localparam int                     DIV100_SH   = 22;
  localparam logic [RECIP_DIG_W-1:0] DIV1000_MUL = 16'd33555;
  localparam int                     DIV1000_SH  = 25;
  localparam int Q10_W   = 12;
  localparam int Q100_W  = 9;
  localparam int Q1000_W = 6;

  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_OFFSET = 2'd0,
    REG_ROI_X      = 2'd1,
    REG_ROI_Y      = 2'd2
  } cfg_reg_e;

  localparam logic signed [OFFSET_W-1:0] CAL_OFFSET_RST = '0;
  localparam logic [ROI_W-1:0]           ROI_RST        = 5'd15;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_PIXEL = 1'b1
  } action_e;

  typedef struct packed {
    action_e                     action;
    logic [PAL_IDX_W-1:0]        palette_index;
    logic [WORD_W-1:0]           palette_word;
    logic signed [RAW_W-1:0]     raw_temp;
  } in_item_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  celsius_tenths;
    logic [WORD_W-1:0]  color_word;
    logic               frame_end;
    logic [TEMP_W-1:0]  roi_average;
    logic [DIGIT_W-1:0] digit_thousands;
    logic [DIGIT_W-1:0] digit_hundreds;
    logic [DIGIT_W-1:0] digit_tens;
    logic [DIGIT_W-1:0] digit_ones;
    logic               average_overflow;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic                 is_pixel;
    logic [PAL_IDX_W-1:0] pal_index;   // write address for loads, read address for pixels
    logic [WORD_W-1:0]    pal_word;
    logic [TEMP_W-1:0]    temp;
    logic                 last;
  } task_t;

endpackage

@@ rtl/tpcra_stream_if.sv @@
// ---------------------------------------------------------------------------
// tpcra_stream_if
// Valid/ready stream channel carrying one request payload.
// ---------------------------------------------------------------------------
interface tpcra_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

@@ rtl/thermal_pixel_colorizer_roi_average.sv @@
// ---------------------------------------------------------------------------
// thermal_pixel_colorizer_roi_average
// Thermal pixel to false-color conversion with window average readout.
// ---------------------------------------------------------------------------
// Requests carry either a palette load (no result) or a pixel (one result).
// One request is taken every cycle while the output is not stalled; a
// pixel's result passes from the head of the two-entry queue to the
// palette read with the average multiply, then to the digit multiplies
// and the output register. The palette is a
// 1200 x 32 single port memory read and written by the back pipeline in
// request order, so a load is visible to every later pixel. The palette has
// no reset and must be loaded before pixels use it; loads beyond the last
// entry are dropped. The window sum is reset with each frame end;
// configuration is applied to pixels accepted after the write.
// ---------------------------------------------------------------------------
module thermal_pixel_colorizer_roi_average #(
  parameter int FRAME_WIDTH   = tpcra_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT  = tpcra_pkg::FRAME_HEIGHT_DEF,
  parameter int WINDOW_WIDTH  = tpcra_pkg::WINDOW_WIDTH_DEF,
  parameter int WINDOW_HEIGHT = tpcra_pkg::WINDOW_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tpcra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpcra_pkg::CFG_DATA_W-1:0] cfg_data,
  tpcra_stream_if.sink                     pixels,
  tpcra_stream_if.source                   results
);

  import tpcra_pkg::*;

  localparam int SUM_W = TEMP_W + $clog2(WINDOW_WIDTH * WINDOW_HEIGHT);
  localparam int QW    = $bits(task_t) + SUM_W;

  logic             push_valid;
  logic             push_ready;
  task_t            push_task;
  logic [SUM_W-1:0] push_sum;
  logic             q_valid;
  logic             q_pop;
  logic [QW-1:0]    q_data;
  task_t            q_task;
  logic [SUM_W-1:0] q_sum;

  tpcra_front #(
    .FRAME_WIDTH   (FRAME_WIDTH),
    .FRAME_HEIGHT  (FRAME_HEIGHT),
    .WINDOW_WIDTH  (WINDOW_WIDTH),
    .WINDOW_HEIGHT (WINDOW_HEIGHT),
    .SUM_W         (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixels     (pixels),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_task  (push_task),
    .push_sum   (push_sum)
  );

  tpcra_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_task, push_sum}),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  assign q_task = q_data[QW-1:SUM_W];
  assign q_sum  = q_data[SUM_W-1:0];

  tpcra_back #(
    .WINDOW_WIDTH  (WINDOW_WIDTH),
    .WINDOW_HEIGHT (WINDOW_HEIGHT),
    .SUM_W         (SUM_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_task  (q_task),
    .q_sum   (q_sum),
    .q_pop   (q_pop),
    .results (results)
  );

`ifndef SYNTHESIS
  // outside frame end the average fields stay clear
  a_no_avg_mid_frame: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.payload.frame_end |->
      results.payload.roi_average == '0 && results.payload.digit_thousands == '0 &&
      results.payload.digit_hundreds == '0 && results.payload.digit_tens == '0 &&
      results.payload.digit_ones == '0 && !results.payload.average_overflow)
    else $error("average fields set on a pixel that is not frame end");

  // digits recombine to the average when below the overflow limit
  a_digits_recombine: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.payload.frame_end && !results.payload.average_overflow |->
      results.payload.roi_average ==
        TEMP_W'(results.payload.digit_thousands) * TEMP_W'(THOUSAND) +
        TEMP_W'(results.payload.digit_hundreds) * TEMP_W'(HUNDRED) +
        TEMP_W'(results.payload.digit_tens) * TEMP_W'(DIGIT_BASE) +
        TEMP_W'(results.payload.digit_ones))
    else $error("decimal digits do not match the average");

  a_overflow_thousands: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.payload.frame_end && results.payload.average_overflow |->
      results.payload.digit_thousands == DIGIT_W'(THOUSANDS_MAX))
    else $error("overflow without saturated thousands digit");

  // input side stalls only when the queue holds work
  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    !pixels.ready |-> q_valid)
    else $error("input stalled while queue is empty");
`endif

endmodule

@@ rtl/tpcra_front.sv @@
// ---------------------------------------------------------------------------
// tpcra_front
// Accepts requests, converts temperature, tracks raster position and
// window sum, and pushes classified work into the queue.
// ---------------------------------------------------------------------------
module tpcra_front #(
  parameter int FRAME_WIDTH   = tpcra_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT  = tpcra_pkg::FRAME_HEIGHT_DEF,
  parameter int WINDOW_WIDTH  = tpcra_pkg::WINDOW_WIDTH_DEF,
  parameter int WINDOW_HEIGHT = tpcra_pkg::WINDOW_HEIGHT_DEF,
  parameter int SUM_W         = tpcra_pkg::TEMP_W
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tpcra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpcra_pkg::CFG_DATA_W-1:0] cfg_data,
  tpcra_stream_if.sink                     pixels,
  input  logic                             push_ready,
  output logic                             push_valid,
  output tpcra_pkg::task_t                 push_task,
  output logic [SUM_W-1:0]                 push_sum
);

  import tpcra_pkg::*;

  localparam int COL_W = $clog2(FRAME_WIDTH);
  localparam int ROW_W = $clog2(FRAME_HEIGHT);
  localparam int WW_W  = $clog2(WINDOW_WIDTH + 1);
  localparam int WH_W  = $clog2(WINDOW_HEIGHT + 1);
  localparam int XW = ((COL_W > ROI_W) ? ((COL_W > WW_W) ? COL_W : WW_W)
                                       : ((ROI_W > WW_W) ? ROI_W : WW_W)) + 1;
  localparam int YW = ((ROW_W > ROI_W) ? ((ROW_W > WH_W) ? ROW_W : WH_W)
                                       : ((ROI_W > WH_W) ? ROI_W : WH_W)) + 1;
  localparam int TF_W = RAW_W + 2;
  localparam int IDX_SUM_W = TEMP_W + 1;

  logic signed [OFFSET_W-1:0] cal_offset;
  logic [ROI_W-1:0]           roi_x;
  logic [ROI_W-1:0]           roi_y;
  logic [COL_W-1:0]           column_count;
  logic [ROW_W-1:0]           row_count;
  logic [SUM_W-1:0]           window_sum;

  logic signed [TF_W-1:0]     t_full;
  logic [TEMP_W-1:0]          temp;
  logic [IDX_SUM_W-1:0]       idx_sum;
  logic [PAL_IDX_W-1:0]       rd_index;
  logic                       in_window;
  logic                       last;
  logic                       is_pixel;
  logic                       accept;
  logic [SUM_W-1:0]           sum_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_offset <= CAL_OFFSET_RST;
      roi_x      <= ROI_RST;
      roi_y      <= ROI_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAL_OFFSET: cal_offset <= cfg_data;
        REG_ROI_X:      roi_x      <= cfg_data[ROI_W-1:0];
        REG_ROI_Y:      roi_y      <= cfg_data[ROI_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    t_full = TF_W'(pixels.payload.raw_temp) - TF_W'(KELVIN_BIAS) + TF_W'(cal_offset);
    if (t_full < 0) begin
      temp = '0;
    end else if (t_full > TF_W'(TEMP_MAX)) begin
      temp = TEMP_W'(TEMP_MAX);
    end else begin
      temp = t_full[TEMP_W-1:0];
    end

    idx_sum = IDX_SUM_W'(temp) + IDX_SUM_W'(INDEX_BIAS);
    if (idx_sum > IDX_SUM_W'(INDEX_MAX)) begin
      rd_index = PAL_IDX_W'(INDEX_MAX);
    end else begin
      rd_index = idx_sum[PAL_IDX_W-1:0];
    end

    in_window = (XW'(column_count) >= XW'(roi_x)) &&
                (XW'(column_count) <  XW'(roi_x) + XW'(WINDOW_WIDTH)) &&
                (YW'(row_count)    >= YW'(roi_y)) &&
                (YW'(row_count)    <  YW'(roi_y) + YW'(WINDOW_HEIGHT));

    last = (column_count == COL_W'(FRAME_WIDTH - 1)) &&
           (row_count == ROW_W'(FRAME_HEIGHT - 1));

    sum_next = in_window ? window_sum + SUM_W'(temp) : window_sum;
  end

  assign is_pixel     = (pixels.payload.action == ACT_PIXEL);
  assign pixels.ready = push_ready;
  assign accept       = pixels.valid && push_ready;

  // out-of-range palette loads are dropped here
  assign push_valid = pixels.valid &&
                      (is_pixel || (pixels.payload.palette_index < PAL_IDX_W'(PALETTE_SIZE)));

  always_comb begin
    push_task.is_pixel  = is_pixel;
    push_task.pal_index = is_pixel ? rd_index : pixels.payload.palette_index;
    push_task.pal_word  = pixels.payload.palette_word;
    push_task.temp      = temp;
    push_task.last      = last;
  end

  assign push_sum = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      window_sum   <= '0;
    end else if (accept && is_pixel) begin
      if (last) begin
        column_count <= '0;
        row_count    <= '0;
        window_sum   <= '0;
      end else begin
        window_sum <= sum_next;
        if (column_count == COL_W'(FRAME_WIDTH - 1)) begin
          column_count <= '0;
          row_count    <= row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/tpcra_queue.sv @@
// ---------------------------------------------------------------------------
// tpcra_queue
// Short FIFO decoupling the front from the back pipeline.
// ---------------------------------------------------------------------------
module tpcra_queue #(
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data
);

  import tpcra_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/tpcra_back.sv @@
// ---------------------------------------------------------------------------
// tpcra_back
// Palette memory, window average and decimal digits; three stages ending
// in the output register. The whole pipeline holds while the output stalls.
// ---------------------------------------------------------------------------
module tpcra_back #(
  parameter int WINDOW_WIDTH  = tpcra_pkg::WINDOW_WIDTH_DEF,
  parameter int WINDOW_HEIGHT = tpcra_pkg::WINDOW_HEIGHT_DEF,
  parameter int SUM_W         = tpcra_pkg::TEMP_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  tpcra_pkg::task_t q_task,
  input  logic [SUM_W-1:0] q_sum,
  output logic             q_pop,
  tpcra_stream_if.source   results
);

  import tpcra_pkg::*;

  // average = floor(sum / AREA) as (sum * RECIP) >> AVG_SH, exact for SUM_W-bit sums
  localparam int AREA    = WINDOW_WIDTH * WINDOW_HEIGHT;
  localparam int AREA_W  = $clog2(AREA);
  localparam int AVG_SH  = SUM_W + AREA_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << AVG_SH) + 64'(AREA) - 64'd1) / 64'(AREA);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam int PROD_W  = SUM_W + RECIP_W;

  logic [WORD_W-1:0] palette_store [PALETTE_SIZE];

  logic en;

  // stage 1
  logic              v1;
  logic [WORD_W-1:0] color1;
  logic [TEMP_W-1:0] temp1;
  logic              last1;
  logic [PROD_W-1:0] prod1;

  // stage 2
  logic                  v2;
  logic [WORD_W-1:0]     color2;
  logic [TEMP_W-1:0]     temp2;
  logic                  last2;
  logic [TEMP_W-1:0]     avg2;
  logic [PROD_DIG_W-1:0] p10;
  logic [PROD_DIG_W-1:0] p100;
  logic [PROD_DIG_W-1:0] p1000;

  // stage 3 / output
  logic      v3;
  out_item_t out_reg;
  out_item_t out_next;

  logic [TEMP_W-1:0]  avg1;
  logic [Q10_W-1:0]   q10;
  logic [Q100_W-1:0]  q100;
  logic [Q1000_W-1:0] q1000;

  assign en    = !v3 || results.ready;
  assign q_pop = en;

  always_ff @(posedge clk) begin
    if (en && q_valid && !q_task.is_pixel) begin
      palette_store[q_task.pal_index] <= q_task.pal_word;
    end
    if (en) begin
      color1 <= palette_store[q_task.pal_index];
    end
  end

  assign avg1 = prod1[AVG_SH +: TEMP_W];

  always_ff @(posedge clk) begin
    if (en) begin
      temp1  <= q_task.temp;
      last1  <= q_task.last;
      prod1  <= PROD_W'(q_sum) * PROD_W'(RECIP);
      color2 <= color1;
      temp2  <= temp1;
      last2  <= last1;
      avg2   <= avg1;
      p10    <= PROD_DIG_W'(avg1) * PROD_DIG_W'(DIV10_MUL);
      p100   <= PROD_DIG_W'(avg1) * PROD_DIG_W'(DIV100_MUL);
      p1000  <= PROD_DIG_W'(avg1) * PROD_DIG_W'(DIV1000_MUL);
      out_reg <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= q_valid && q_task.is_pixel;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // hundreds, tens, ones: a quotient or the average less ten times the next quotient
  always_comb begin
    q10   = p10[DIV10_SH +: Q10_W];
    q100  = p100[DIV100_SH +: Q100_W];
    q1000 = p1000[DIV1000_SH +: Q1000_W];

    out_next                = '0;
    out_next.celsius_tenths = temp2;
    out_next.color_word     = color2;
    out_next.frame_end      = last2;
    if (last2) begin
      out_next.roi_average = avg2;
      out_next.digit_thousands = (q1000 > Q1000_W'(THOUSANDS_MAX)) ?
                                 DIGIT_W'(THOUSANDS_MAX) : q1000[DIGIT_W-1:0];
      out_next.digit_hundreds =
        DIGIT_W'(q100 - Q100_W'(q1000) * Q100_W'(DIGIT_BASE));
      out_next.digit_tens =
        DIGIT_W'(q10 - Q10_W'(q100) * Q10_W'(DIGIT_BASE));
      out_next.digit_ones =
        DIGIT_W'(avg2 - TEMP_W'(q10) * TEMP_W'(DIGIT_BASE));
      out_next.average_overflow = (avg2 >= TEMP_W'(OVERFLOW_LIMIT));
    end
  end

  assign results.valid   = v3;
  assign results.payload = out_reg;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Streams palette loads and thermal pixels into the colorizer under random
// sender bursts and receiver stalls. A local model predicts each pixel's
// Celsius value, color word and frame-end window average, and the results
// are checked in order. Register settings change between drained phases.
// ---------------------------------------------------------------------------
module testbench;
  import tpcra_pkg::*;

  localparam int FRAME_W = FRAME_WIDTH_DEF;
  localparam int FRAME_H = FRAME_HEIGHT_DEF;
  localparam int WIN_W   = WINDOW_WIDTH_DEF;
  localparam int WIN_H   = WINDOW_HEIGHT_DEF;

  localparam int SETTLE_CYCLES    = 12;
  localparam int LONG_HOLD_CYCLES = 160;
  localparam int HOLD_ITEMS       = 64;
  localparam int REPORT_LIMIT     = 10;
  localparam int PHASES           = 11;
  localparam int PHASE_ITEMS      = 130;
  localparam int HOLD_PHASE       = 2;

  typedef enum int {TEMP_NORMAL, TEMP_WIDE, TEMP_HOT} temp_profile_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tpcra_stream_if #(.payload_t(in_item_t))  pixels_if ();
  tpcra_stream_if #(.payload_t(out_item_t)) results_if ();

  thermal_pixel_colorizer_roi_average #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H),
    .WINDOW_WIDTH (WIN_W),
    .WINDOW_HEIGHT(WIN_H)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixels   (pixels_if),
    .results  (results_if)
  );

  always #5 clk = ~clk;

  // model state
  logic [WORD_W-1:0]          palette_copy [PALETTE_SIZE];
  int                         col_pos      = 0;
  int                         row_pos      = 0;
  int                         window_total = 0;
  logic signed [OFFSET_W-1:0] offset_now   = CAL_OFFSET_RST;
  logic [ROI_W-1:0]           roi_x_now    = ROI_RST;
  logic [ROI_W-1:0]           roi_y_now    = ROI_RST;

  in_item_t  requests_pending [$];
  out_item_t colorized_due [$];
  int        mismatches = 0;

  bit sender_gaps_on     = 1'b0;
  bit receiver_stalls_on = 1'b0;
  bit receiver_hold      = 1'b0;
  event long_hold_go;

  int corner_temps [16] = '{-32768, 32767, 0, -1, 2731, 2732, 2733, 3330,
                            3331, 3332, 3333, 4732, 12731, 12732, 12731, 5000};

  function automatic in_item_t load_request(input logic [PAL_IDX_W-1:0] idx,
                                            input logic [WORD_W-1:0] word);
    in_item_t r;
    r.action        = ACT_LOAD;
    r.palette_index = idx;
    r.palette_word  = word;
    r.raw_temp      = RAW_W'($urandom);
    return r;
  endfunction

  function automatic in_item_t pixel_request(input logic [RAW_W-1:0] raw);
    in_item_t r;
    r.action        = ACT_PIXEL;
    r.palette_index = PAL_IDX_W'($urandom);
    r.palette_word  = $urandom;
    r.raw_temp      = raw;
    return r;
  endfunction

  function automatic in_item_t random_request(input temp_profile_e profile);
    logic [RAW_W-1:0] raw;
    int               idx;
    if ($urandom_range(0, 7) == 0) begin
      // a quarter of loads may land beyond the palette and be dropped
      idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                        : $urandom_range(0, PALETTE_SIZE - 1);
      return load_request(PAL_IDX_W'(idx), $urandom);
    end
    if ($urandom_range(0, 9) == 0) profile = TEMP_WIDE;
    case (profile)
      TEMP_HOT:  raw = RAW_W'($urandom_range(12000, 32767));
      TEMP_WIDE: raw = RAW_W'($urandom);
      default:   raw = RAW_W'($urandom_range(1700, 4300));
    endcase
    return pixel_request(raw);
  endfunction

  // applies one accepted request to the model; pixels queue their result
  task automatic colorize_request(input in_item_t req);
    int        celsius;
    int        offs;
    int        pal_addr;
    int        average;
    int        wx;
    int        wy;
    out_item_t res;
    if (req.action == ACT_LOAD) begin
      if (req.palette_index < PALETTE_SIZE) palette_copy[req.palette_index] = req.palette_word;
      return;
    end
    celsius = int'(req.raw_temp);
    offs    = int'(offset_now);
    celsius = celsius - KELVIN_BIAS + offs;
    if (celsius < 0) celsius = 0;
    if (celsius > TEMP_MAX) celsius = TEMP_MAX;
    pal_addr = celsius + INDEX_BIAS;
    if (pal_addr > INDEX_MAX) pal_addr = INDEX_MAX;
    wx = int'(roi_x_now);
    wy = int'(roi_y_now);
    if (col_pos >= wx && col_pos < wx + WIN_W && row_pos >= wy && row_pos < wy + WIN_H)
      window_total += celsius;
    res                = '0;
    res.celsius_tenths = celsius[TEMP_W-1:0];
    res.color_word     = palette_copy[pal_addr];
    res.frame_end      = (col_pos == FRAME_W - 1) && (row_pos == FRAME_H - 1);
    if (res.frame_end) begin
      average = window_total / (WIN_W * WIN_H);
      if (average > TEMP_MAX) average = TEMP_MAX;
      res.roi_average      = average[TEMP_W-1:0];
      res.digit_thousands  = DIGIT_W'((average / THOUSAND > THOUSANDS_MAX) ?
                                      THOUSANDS_MAX : average / THOUSAND);
      res.digit_hundreds   = DIGIT_W'((average / HUNDRED) % DIGIT_BASE);
      res.digit_tens       = DIGIT_W'((average / DIGIT_BASE) % DIGIT_BASE);
      res.digit_ones       = DIGIT_W'(average % DIGIT_BASE);
      res.average_overflow = (average >= OVERFLOW_LIMIT);
      col_pos      = 0;
      row_pos      = 0;
      window_total = 0;
    end else if (col_pos == FRAME_W - 1) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
    colorized_due.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  task automatic write_register(input cfg_reg_e which, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_settings(input int offs, input int rx, input int ry);
    write_register(REG_CAL_OFFSET, CFG_DATA_W'(offs));
    write_register(REG_ROI_X, CFG_DATA_W'(rx));
    write_register(REG_ROI_Y, CFG_DATA_W'(ry));
    offset_now = OFFSET_W'(offs);
    roi_x_now  = ROI_W'(rx);
    roi_y_now  = ROI_W'(ry);
  endtask

  // wait until no request is queued or offered and no result is owed
  task automatic drain();
    do @(negedge clk);
    while (requests_pending.size() != 0 || pixels_if.valid || colorized_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length with random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      pixels_if.valid <= 1'b0;
      burst_left      <= 0;
      gap_left        <= 0;
    end else if (!pixels_if.valid || pixels_if.ready) begin
      if (gap_left != 0) begin
        gap_left        <= gap_left - 1;
        pixels_if.valid <= 1'b0;
      end else if (requests_pending.size() != 0) begin
        pixels_if.valid   <= 1'b1;
        pixels_if.payload <= requests_pending.pop_front();
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= sender_gaps_on ? $urandom_range(1, 6) : 0;
        end
      end else begin
        pixels_if.valid <= 1'b0;
      end
    end
  end

  // receiver stall mask, reloaded on each wrap of its phase with varying density
  logic [15:0] stall_mask;
  int          stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      stall_mask       <= '0;
      stall_phase      <= 0;
    end else begin
      results_if.ready <= !receiver_hold && !(receiver_stalls_on && stall_mask[stall_phase]);
      stall_phase      <= (stall_phase + 1) % 16;
      if (stall_phase == 15) begin
        case ($urandom_range(0, 2))
          0:       stall_mask <= 16'($urandom & $urandom);
          1:       stall_mask <= 16'($urandom);
          default: stall_mask <= 16'($urandom | $urandom);
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(long_hold_go);
      @(posedge clk);
      receiver_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clk);
      receiver_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && pixels_if.valid && pixels_if.ready) colorize_request(pixels_if.payload);
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && results_if.valid && results_if.ready) begin
      got = results_if.payload;
      if (colorized_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("result with none pending: %p", got);
      end else begin
        want = colorized_due.pop_front();
        check_field("celsius_tenths", WORD_W'(want.celsius_tenths),
                    WORD_W'(got.celsius_tenths));
        check_field("color_word", want.color_word, got.color_word);
        check_field("frame_end", WORD_W'(want.frame_end), WORD_W'(got.frame_end));
        check_field("roi_average", WORD_W'(want.roi_average), WORD_W'(got.roi_average));
        check_field("digit_thousands", WORD_W'(want.digit_thousands),
                    WORD_W'(got.digit_thousands));
        check_field("digit_hundreds", WORD_W'(want.digit_hundreds),
                    WORD_W'(got.digit_hundreds));
        check_field("digit_tens", WORD_W'(want.digit_tens), WORD_W'(got.digit_tens));
        check_field("digit_ones", WORD_W'(want.digit_ones), WORD_W'(got.digit_ones));
        check_field("average_overflow", WORD_W'(want.average_overflow),
                    WORD_W'(got.average_overflow));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    temp_profile_e profile;
    int            count;
    cfg_we            = 1'b0;
    cfg_index         = REG_CAL_OFFSET;
    cfg_data          = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // every palette entry a pixel can reach is written before any pixel reads it
    apply_settings(0, 0, 0);
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    for (int i = INDEX_BIAS; i <= INDEX_MAX; i++)
      requests_pending.push_back(load_request(PAL_IDX_W'(i), $urandom));
    drain();

    // clamps, index saturation, word extremes, dropped loads
    requests_pending.push_back(load_request(11'd600, 32'h0000_0000));
    requests_pending.push_back(load_request(11'd1199, 32'hFFFF_FFFF));
    requests_pending.push_back(load_request(11'd1024, 32'hA5A5_5A5A));
    requests_pending.push_back(load_request(11'd1200, 32'h1234_5678));
    requests_pending.push_back(load_request(11'd2047, 32'h5A5A_A5A5));
    foreach (corner_temps[i]) requests_pending.push_back(pixel_request(RAW_W'(corner_temps[i])));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      count              = PHASE_ITEMS;
      sender_gaps_on     = ($urandom_range(0, 3) != 0);
      receiver_stalls_on = ($urandom_range(0, 3) != 0);
      profile            = temp_profile_e'($urandom_range(0, 2));
      case (p)
        0: begin
          // window in the far corner of the frame, no idling
          apply_settings(-1000, 28, 28);
          sender_gaps_on     = 1'b0;
          receiver_stalls_on = 1'b0;
          profile            = TEMP_NORMAL;
        end
        1: begin
          apply_settings(1000, 0, 0);
          profile = TEMP_HOT;
        end
        HOLD_PHASE: begin
          apply_settings(int'($urandom_range(0, 2000)) - 1000, 0, 0);
          sender_gaps_on = 1'b0;
          count          = HOLD_ITEMS;
          -> long_hold_go;
        end
        default: begin
          apply_settings(int'($urandom_range(0, 2000)) - 1000,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 28)
                                                     : $urandom_range(0, 3),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 28)
                                                     : $urandom_range(0, 3));
        end
      endcase
      for (int i = 0; i < count; i++) requests_pending.push_back(random_request(profile));
      drain();
    end

    if (mismatches == 0 && colorized_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ thermal_pixel_colorizer_roi_average.f @@
rtl/tpcra_pkg.sv
rtl/tpcra_stream_if.sv
rtl/tpcra_front.sv
rtl/tpcra_queue.sv
rtl/tpcra_back.sv
rtl/thermal_pixel_colorizer_roi_average.sv
tb/sv/testbench.sv
